>>> rtl/core/scl_pkg.sv
// Shared types and constants for the shell command line lexer.
// No dependencies; imported by every module of the block.
package scl_pkg;

	localparam int unsigned MaxResults = 4;
	localparam int unsigned IdxW       = $clog2(MaxResults);
	localparam int unsigned CntW       = $clog2(MaxResults + 1);

	// result kinds
	localparam logic [1:0] KIND_BYTE      = 2'd0;
	localparam logic [1:0] KIND_END_TOKEN = 2'd1;
	localparam logic [1:0] KIND_END_LINE  = 2'd2;

	// quote state
	localparam logic [1:0] QUOTE_NONE   = 2'd0;
	localparam logic [1:0] QUOTE_SINGLE = 2'd1;
	localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

	// characters
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NONE   = 8'h00;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ch;
	} scl_result_t;

	// all results caused by one input item
	typedef struct packed {
		logic [CntW-1:0]                   count;
		scl_result_t [MaxResults-1:0]      res;
	} scl_group_t;

	// handshake between the input stage and the output buffer
	typedef struct packed {
		logic load;
		logic can_take;
	} scl_ctrl_t;

	function automatic logic is_operator(input logic [7:0] c);
		return (c == CH_PIPE) || (c == CH_AMP) || (c == CH_SEMI) ||
			(c == CH_GT) || (c == CH_LT);
	endfunction

endpackage

>>> rtl/core/scl_lexer.sv
// Lexer state registers and the single-pass step logic for one input item.
// Depends on scl_pkg.
module scl_lexer
	import scl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] ch,
	input  logic       eol,
	output scl_group_t group
);

	logic [1:0] quote_q, quote_d;
	logic [7:0] held_q, held_d;
	logic       space_q, space_d;
	logic       open_q, open_d;
	logic       done;
	logic [CntW-1:0] n;

	always_comb begin
		quote_d = quote_q;
		held_d  = held_q;
		space_d = space_q;
		open_d  = open_q;
		done    = 1'b0;
		n       = '0;
		group   = '0;
		if (eol) begin
			if (held_q != CH_NONE) begin
				group.res[n[IdxW-1:0]] = '{KIND_BYTE, held_q};
				n = n + 1'b1;
				group.res[n[IdxW-1:0]] = '{KIND_END_TOKEN, CH_NONE};
				n = n + 1'b1;
			end else if (open_q) begin
				group.res[n[IdxW-1:0]] = '{KIND_END_TOKEN, CH_NONE};
				n = n + 1'b1;
			end
			group.res[n[IdxW-1:0]] = '{KIND_END_LINE, CH_NONE};
			n = n + 1'b1;
			quote_d = QUOTE_NONE;
			held_d  = CH_NONE;
			space_d = 1'b0;
			open_d  = 1'b0;
		end else begin
			if (held_q != CH_NONE) begin
				held_d = CH_NONE;
				group.res[n[IdxW-1:0]] = '{KIND_BYTE, held_q};
				n = n + 1'b1;
				if (ch == held_q) begin
					group.res[n[IdxW-1:0]] = '{KIND_BYTE, ch};
					n = n + 1'b1;
					done = 1'b1;
				end
				group.res[n[IdxW-1:0]] = '{KIND_END_TOKEN, CH_NONE};
				n = n + 1'b1;
			end
			if (!done) begin
				if (quote_q != QUOTE_NONE) begin
					if ((quote_q == QUOTE_SINGLE && ch == CH_SQUOTE) ||
						(quote_q == QUOTE_DOUBLE && ch == CH_DQUOTE)) begin
						quote_d = QUOTE_NONE;
					end else begin
						group.res[n[IdxW-1:0]] = '{KIND_BYTE, ch};
						n = n + 1'b1;
						open_d = 1'b1;
					end
				end else if (ch == CH_SPACE) begin
					if (open_q)
						space_d = 1'b1;
				end else if (is_operator(ch)) begin
					space_d = 1'b0;
					open_d  = 1'b0;
					if (open_q) begin
						group.res[n[IdxW-1:0]] = '{KIND_END_TOKEN, CH_NONE};
						n = n + 1'b1;
					end
					if (ch == CH_SEMI) begin
						group.res[n[IdxW-1:0]] = '{KIND_BYTE, ch};
						n = n + 1'b1;
						group.res[n[IdxW-1:0]] = '{KIND_END_TOKEN, CH_NONE};
						n = n + 1'b1;
					end else begin
						held_d = ch;
					end
				end else begin
					if (space_q) begin
						group.res[n[IdxW-1:0]] = '{KIND_BYTE, CH_SPACE};
						n = n + 1'b1;
					end
					space_d = 1'b0;
					if (ch == CH_SQUOTE) begin
						quote_d = QUOTE_SINGLE;
					end else if (ch == CH_DQUOTE) begin
						quote_d = QUOTE_DOUBLE;
					end else begin
						group.res[n[IdxW-1:0]] = '{KIND_BYTE, ch};
						n = n + 1'b1;
						open_d = 1'b1;
					end
				end
			end
		end
		group.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q <= QUOTE_NONE;
			held_q  <= CH_NONE;
			space_q <= 1'b0;
			open_q  <= 1'b0;
		end else if (step) begin
			quote_q <= quote_d;
			held_q  <= held_d;
			space_q <= space_d;
			open_q  <= open_d;
		end
	end

`ifndef SYNTHESIS
	// an operator is only ever held outside quotes
	a_held_unquoted: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != CH_NONE |-> quote_q == QUOTE_NONE)
		else $error("operator held inside quotes");

	// holding an operator closes the word
	a_held_closed: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != CH_NONE |-> !open_q && !space_q)
		else $error("operator held with open word");

	// only doubling operators are held
	a_held_char: assert property (@(posedge clk) disable iff (!arst_n)
		held_q == CH_NONE || held_q == CH_PIPE || held_q == CH_AMP ||
		held_q == CH_GT || held_q == CH_LT)
		else $error("bad held operator");

	// a pending space needs an open word
	a_space_open: assert property (@(posedge clk) disable iff (!arst_n)
		space_q |-> open_q)
		else $error("space pending outside a word");
`endif

endmodule

>>> rtl/core/scl_outbuf.sv
// Output register: holds the results of one item and sends them one per transfer.
// Depends on scl_pkg.
module scl_outbuf
	import scl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load_valid,
	input  scl_group_t group,
	output scl_ctrl_t  ctrl,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_char
	output logic [1:0] m_axis_tuser,   // [1:0] kind
	output logic       m_axis_tlast    // last
);

	logic                         busy_q;
	logic [CntW-1:0]              cnt_q;
	logic [IdxW-1:0]              idx_q;
	scl_result_t [MaxResults-1:0] res_q;
	logic                         drain;
	logic                         load;

	assign m_axis_tvalid = busy_q;
	assign m_axis_tlast  = {1'b0, idx_q} == cnt_q - 1'b1;
	assign m_axis_tdata  = res_q[idx_q].ch;
	assign m_axis_tuser  = res_q[idx_q].kind;

	assign drain = busy_q && m_axis_tready;
	assign ctrl.can_take = !busy_q || (drain && m_axis_tlast);
	assign load = load_valid && ctrl.can_take;
	assign ctrl.load = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			idx_q  <= '0;
		end else if (load) begin
			// items without results leave the buffer empty
			busy_q <= group.count != '0;
			cnt_q  <= group.count;
			idx_q  <= '0;
		end else if (drain) begin
			if (m_axis_tlast)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= group.res;
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0) && (cnt_q <= CntW'(MaxResults)))
		else $error("result count out of range");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> {1'b0, idx_q} < cnt_q)
		else $error("result index past count");

	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		drain && m_axis_tlast && !load |=> !busy_q)
		else $error("buffer busy after final transfer");
`endif

endmodule

>>> rtl/core/shell_command_line_lexer.sv
// Shell command line lexer, top level. The first result of an input item is valid
// after the input register, then the result register.
// Throughput: one item per cycle if each item yields at most one result and the
// output is not stalled; an item's results (up to 4) hold the output register.
// Reset (arst_n low, asynchronous): outside quotes, nothing held, no open word,
// both stages empty.
module shell_command_line_lexer
	import scl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] ch
	input  logic       s_axis_tlast,   // end_of_line
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_char
	output logic [1:0] m_axis_tuser,   // [1:0] kind
	output logic       m_axis_tlast    // last
);

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       eol_s1;
	scl_group_t group;
	scl_ctrl_t  ctrl;

	// advance the input stage whenever the output register can take its results
	assign s_axis_tready = !valid_s1 || ctrl.can_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ch_s1  <= s_axis_tdata;
			eol_s1 <= s_axis_tlast;
		end
	end

	scl_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (ctrl.load),
		.ch     (ch_s1),
		.eol    (eol_s1),
		.group  (group)
	);

	scl_outbuf u_outbuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load_valid    (valid_s1),
		.group         (group),
		.ctrl          (ctrl),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
